// ===== hdl/dcsd_pkg.sv =====
package dcsd_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned WORD_W          = 23;
  localparam int unsigned CODE_W          = 9;
  localparam int unsigned PAR_N           = 11;
  localparam int unsigned CACHE_DEPTH_DEF = 12;

  localparam logic [WORD_W-1:0] EOT_PATTERN = 23'h555555;
  localparam logic [2:0]        MARKER      = 3'b100;   // bits 11..9
  localparam logic [PAR_N-1:0]  PAR_INVERT  = 11'h63A;

  localparam logic [CODE_W-1:0] PAR_MASK [PAR_N] = '{
    9'h09F, 9'h13E, 9'h0E3, 9'h1C6, 9'h113, 9'h0B9,
    9'h1ED, 9'h1DA, 9'h1B4, 9'h168, 9'h04F
  };

  localparam logic EVT_NEW_CODE = 1'b0;
  localparam logic EVT_END      = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WORD_W-1:0]          word_t;
  typedef logic [CODE_W-1:0]          code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic {
    CACHE_IDLE,
    CACHE_SCAN
  } cache_state_e;

  typedef struct packed {
    logic  ok;
    logic  ok_neg;
    logic  eot;
    code_t code;
  } word_chk_t;

  typedef struct packed {
    logic  start;
    logic  clear;
    code_t code;
  } cache_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } cache_rsp_t;

  // marker plus eleven parity equations over the nine code bits
  function automatic logic golay_ok(word_t w);
    logic [PAR_N-1:0] expect_par;
    for (int k = 0; k < PAR_N; k++) begin
      expect_par[k] = (^(w[CODE_W-1:0] & PAR_MASK[k])) ^ PAR_INVERT[k];
    end
    return (w[11:9] == MARKER) && (w[WORD_W-1:12] == expect_par);
  endfunction

endpackage

// ===== hdl/dcsd_in_if.sv =====
interface dcsd_in_if import dcsd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/dcsd_out_if.sv =====
interface dcsd_out_if import dcsd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  event_kind;
  logic  inverted;
  code_t code;

  modport source (output valid, output event_kind, output inverted, output code, input ready);
  modport sink   (input valid, input event_kind, input inverted, input code, output ready);
endinterface

// ===== hdl/dcsd_word_check.sv =====
module dcsd_word_check import dcsd_pkg::*; (
  input  word_t     word_i,
  output word_chk_t chk_o
);

  word_t neg;
  logic  ok;
  logic  ok_neg;

  assign neg    = ~word_i;
  assign ok     = golay_ok(word_i);
  assign ok_neg = golay_ok(neg);

  always_comb begin
    chk_o.ok     = ok;
    chk_o.ok_neg = ok_neg;
    chk_o.eot    = !ok && !ok_neg && (word_i == EOT_PATTERN);
    // normal word wins; the two markers cannot both match anyway
    chk_o.code   = ok ? word_i[CODE_W-1:0] : neg[CODE_W-1:0];
  end

endmodule

// ===== hdl/dcsd_code_cache.sv =====
module dcsd_code_cache import dcsd_pkg::*; #(
  parameter int unsigned CacheDepth = CACHE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cache_req_t req_i,
  output cache_rsp_t rsp_o
);

  localparam int unsigned IdxW = (CacheDepth > 1) ? $clog2(CacheDepth) : 1;
  localparam int unsigned CntW = $clog2(CacheDepth + 1);

  code_t mem [CacheDepth];

  cache_state_e          state_q, state_d;
  logic [CntW-1:0]       cnt_q;
  logic                  cmp_pend_q;
  logic [IdxW-1:0]       cmp_idx_q;
  logic [IdxW-1:0]       ptr_q;
  logic [CacheDepth-1:0] valid_q;
  code_t                 rd_data_q;
  code_t                 code_q;

  logic issue;
  logic hit;
  logic last;
  logic done;
  logic wr_en;

  assign issue = (state_q == CACHE_SCAN) && (cnt_q < CntW'(CacheDepth));
  assign hit   = cmp_pend_q && valid_q[cmp_idx_q] && (rd_data_q == code_q);
  assign last  = cmp_pend_q && (hit || (cmp_idx_q == IdxW'(CacheDepth - 1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      CACHE_IDLE: begin
        if (req_i.start) state_d = CACHE_SCAN;
      end
      CACHE_SCAN: begin
        if (last) state_d = CACHE_IDLE;
      end
      default: state_d = CACHE_IDLE;
    endcase
  end

  always_comb begin
    done  = (state_q == CACHE_SCAN) && last;
    wr_en = done && !hit;
    rsp_o.done = done;
    rsp_o.hit  = hit;
  end

  // one read per cycle during a scan; the registered read data is compared in the next cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[ptr_q] <= code_q;
    if (issue) rd_data_q <= mem[cnt_q[IdxW-1:0]];
    if (req_i.start && (state_q == CACHE_IDLE)) code_q <= req_i.code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CACHE_IDLE;
      cnt_q      <= '0;
      cmp_pend_q <= 1'b0;
      cmp_idx_q  <= '0;
      ptr_q      <= '0;
      valid_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == CACHE_IDLE) begin
        cnt_q      <= '0;
        cmp_pend_q <= 1'b0;
      end else begin
        if (issue) cnt_q <= cnt_q + CntW'(1);
        cmp_pend_q <= issue && !done;
        cmp_idx_q  <= cnt_q[IdxW-1:0];
      end
      if (req_i.clear) begin
        valid_q <= '0;
        ptr_q   <= '0;
      end else if (wr_en) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q <= (ptr_q == IdxW'(CacheDepth - 1)) ? '0 : ptr_q + IdxW'(1);
      end
    end
  end

endmodule

// ===== hdl/dcs_squelch_code_detector_core.sv =====
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | sample (16, signed)
// out_o   | out | valid / ready | event_kind (1), inverted (1), code (9)
//
// One item at a time. An item whose word is no valid code is taken, then checked.
// A valid word runs a cache scan over up to CACHE_DEPTH entries of the code memory
// (one read port, registered read), so a new code goes through take, check, scan, emit.
// Reset empties the cache at once through per-entry valid bits; no clearing pass.
// A held result in the output register does not stop the next item being taken;
// only a further result waits for it.
module dcs_squelch_code_detector_core import dcsd_pkg::*; #(
  parameter int unsigned CACHE_DEPTH = CACHE_DEPTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  dcsd_in_if.sink     in_i,
  dcsd_out_if.source  out_o
);

  ctrl_state_e state_q, state_d;
  word_t       shift_q;
  word_chk_t   chk;
  cache_req_t  cache_req;
  cache_rsp_t  cache_rsp;

  logic  out_valid_q;
  logic  out_kind_q;
  logic  out_inv_q;
  code_t out_code_q;

  logic out_free;
  logic in_ready;
  logic accept;
  logic new_bit;
  logic load_end;
  logic load_code;

  dcsd_word_check u_check (
    .word_i (shift_q),
    .chk_o  (chk)
  );

  dcsd_code_cache #(
    .CacheDepth (CACHE_DEPTH)
  ) u_cache (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cache_req),
    .rsp_o  (cache_rsp)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_ready;
  assign new_bit  = !in_i.sample[SAMPLE_W-1] && (|in_i.sample);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (chk.ok || chk.ok_neg) state_d = ST_SCAN;
        else if (!chk.eot || out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (cache_rsp.done) state_d = cache_rsp.hit ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_q == ST_IDLE);
    cache_req.start = (state_q == ST_CHECK) && (chk.ok || chk.ok_neg);
    cache_req.code  = chk.code;
    load_end        = (state_q == ST_CHECK) && chk.eot && out_free;
    cache_req.clear = load_end;
    load_code       = (state_q == ST_EMIT) && out_free;
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = out_kind_q;
  assign out_o.inverted   = out_inv_q;
  assign out_o.code       = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_end) shift_q <= '0;
      else if (accept) shift_q <= {new_bit, shift_q[WORD_W-1:1]};
      if (load_end || load_code) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_end) begin
      out_kind_q <= EVT_END;
      out_inv_q  <= 1'b0;
      out_code_q <= '0;
    end else if (load_code) begin
      // shift word holds still until the next item, so the check is still valid
      out_kind_q <= EVT_NEW_CODE;
      out_inv_q  <= !chk.ok;
      out_code_q <= chk.code;
    end
  end

endmodule

// ===== dv/dcs_squelch_code_detector_checker.sv =====
module dcs_squelch_code_detector_checker import dcsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcsd_in_if          in_i,
  dcsd_out_if         out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned SEEN_DEPTH = CACHE_DEPTH_DEF;

  // parity taps over code bits 8..0, one per parity bit 12..22
  localparam logic [8:0] GOLAY_TAP [11] = '{
    9'h09F, 9'h13E, 9'h0E3, 9'h1C6, 9'h113, 9'h0B9,
    9'h1ED, 9'h1DA, 9'h1B4, 9'h168, 9'h04F
  };
  localparam logic [10:0] GOLAY_FLIP = 11'h63A;

  typedef struct packed {
    logic  kind;
    logic  inverted;
    code_t code;
  } dcs_event_t;

  word_t       rx_word;
  code_t       seen_code [SEEN_DEPTH];
  logic        seen_vld  [SEEN_DEPTH];
  int unsigned fill_ptr;
  dcs_event_t  awaited_events [$];

  initial begin
    rx_word      = '0;
    fill_ptr     = 0;
    for (int i = 0; i < SEEN_DEPTH; i++) begin
      seen_code[i] = '0;
      seen_vld[i]  = 1'b0;
    end
  end

  function automatic logic codeword_good(word_t w);
    logic [10:0] par;
    for (int k = 0; k < 11; k++) begin
      par[k] = (^(w[8:0] & GOLAY_TAP[k])) ^ GOLAY_FLIP[k];
    end
    return (w[11] && !w[10] && !w[9]) && (w[22:12] == par);
  endfunction

  task automatic track_sample(sample_t s);
    word_t      inv_word;
    logic       ok;
    logic       ok_inv;
    logic       hit;
    dcs_event_t ev;
    rx_word  = {($signed(s) > 0), rx_word[WORD_W-1:1]};
    inv_word = ~rx_word;
    ok       = codeword_good(rx_word);
    ok_inv   = codeword_good(inv_word);
    if (!ok && !ok_inv) begin
      if (rx_word == 23'h555555) begin
        rx_word  = '0;
        fill_ptr = 0;
        for (int i = 0; i < SEEN_DEPTH; i++) begin
          seen_code[i] = '0;
          seen_vld[i]  = 1'b0;
        end
        ev = '{kind: EVT_END, inverted: 1'b0, code: '0};
        awaited_events.push_back(ev);
      end
    end else begin
      ev  = '{kind: EVT_NEW_CODE, inverted: !ok, code: ok ? rx_word[8:0] : inv_word[8:0]};
      hit = 1'b0;
      for (int i = 0; i < SEEN_DEPTH; i++) begin
        if (seen_vld[i] && seen_code[i] == ev.code) hit = 1'b1;
      end
      if (!hit) begin
        seen_code[fill_ptr] = ev.code;
        seen_vld[fill_ptr]  = 1'b1;
        fill_ptr            = (fill_ptr + 1) % SEEN_DEPTH;
        awaited_events.push_back(ev);
      end
    end
  endtask

  always @(posedge clk_i) begin
    dcs_event_t want;
    dcs_event_t got;
    if (rst_ni) begin
      // results always come out after their item is taken, so check first
      if (out_i.valid && out_i.ready) begin
        got = '{kind: out_i.event_kind, inverted: out_i.inverted, code: out_i.code};
        if (awaited_events.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected event kind %0d inv %0d code %03o",
                     $realtime, got.kind, got.inverted, got.code);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = awaited_events.pop_front();
          if (got.kind !== want.kind || got.inverted !== want.inverted ||
              got.code !== want.code) begin
            if (fail_count_o < 10) begin
              $display("%0t: event kind %0d inv %0d code %03o, expected %0d %0d %03o",
                       $realtime, got.kind, got.inverted, got.code,
                       want.kind, want.inverted, want.code);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_i.valid && in_i.ready) track_sample(in_i.sample);
      pending_o <= awaited_events.size();
    end
  end

endmodule

// ===== dv/dcs_squelch_code_detector_core_tb.sv =====
module dcs_squelch_code_detector_core_tb;
  import dcsd_pkg::*;

  localparam int unsigned ITEMS       = 1300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN       = 2 * CACHE_DEPTH_DEF + 8;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned sent;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  code_t       code_pool [16];

  dcsd_in_if  in_if ();
  dcsd_out_if out_if ();

  dcs_squelch_code_detector_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dcs_squelch_code_detector_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic word_t dcs_word(code_t c);
    logic [PAR_N-1:0] p;
    for (int k = 0; k < PAR_N; k++) begin
      p[k] = (^(c & PAR_MASK[k])) ^ PAR_INVERT[k];
    end
    return {p, MARKER, c};
  endfunction

  function automatic sample_t bit_sample(logic b);
    if (b) return sample_t'($urandom_range(32767, 1));
    if ($urandom_range(7) == 0) return sample_t'(0);
    return sample_t'(32'd65536 - $urandom_range(32768, 1));
  endfunction

  task automatic push_sample(sample_t s);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  // oldest bit first: it ends up in bit 0 once all 23 have shifted in
  task automatic send_word(word_t w);
    for (int i = 0; i < WORD_W; i++) push_sample(bit_sample(w[i]));
  endtask

  initial begin
    word_t       w;
    int unsigned pick;
    int unsigned phase;
    int unsigned cur_phase;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    rst_ni       = 1'b0;
    sent         = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    cur_phase    = 0;
    code_pool[0] = '0;
    code_pool[1] = '1;
    for (int i = 2; i < 16; i++) code_pool[i] = code_t'($urandom_range(511));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one clean code word built from the sample extremes
    w = dcs_word(9'o023);
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) push_sample((i & 1) ? sample_t'(1) : sample_t'(32767));
      else if (i % 3 == 0) push_sample(sample_t'(0));
      else if (i % 3 == 1) push_sample(sample_t'(-1));
      else push_sample(sample_t'(-32768));
    end

    while (sent < ITEMS) begin
      phase = (sent * 4) / ITEMS;
      if (phase != cur_phase) begin
        in_if.valid <= 1'b0;
        // let the count take in the item accepted at this edge
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        @(posedge clk_i);
        cur_phase = phase;
        case (phase)
          1: begin
            tx_idle_pct  = 59;
            rx_stall_pct = 0;
          end
          2: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 59;
          end
          default: begin
            tx_idle_pct  = 20;
            rx_stall_pct = 20;
          end
        endcase
      end
      pick = $urandom_range(99);
      w    = dcs_word(code_pool[$urandom_range(15)]);
      if (pick < 50) begin
        send_word(w);
      end else if (pick < 72) begin
        send_word(~w);
      end else if (pick < 82) begin
        send_word(EOT_PATTERN);
      end else if (pick < 92) begin
        // corrupted word: one flipped bit, either polarity
        w[$urandom_range(WORD_W - 1)] ^= 1'b1;
        send_word($urandom_range(1) ? w : ~w);
      end else begin
        repeat ($urandom_range(12, 1)) push_sample(sample_t'($urandom_range(65535)));
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
